// ===== hdl/itaf_pkg.sv =====
package itaf_pkg;

  localparam int DEC_DIGITS    = 10;
  localparam int HEX_DIGITS    = 8;
  localparam int DEC_WIDTH_MAX = 9;
  localparam int HEX_WIDTH_MAX = 8;

  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  // 'A' - 10, so that a digit of ten and up maps onto 'A'..'F'
  localparam logic [7:0] CHAR_HEX_BASE = 8'h37;

  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  // One classified word handed from the front to the back
  typedef struct packed {
    logic        hex;
    logic [31:0] value;
    logic [3:0]  top_pos;   // index of the most significant digit position shown
    logic        has_width;
    logic        zero_pad;
  } job_t;

  // Queue handshake seen by the back
  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_HEX_BASE + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// ===== hdl/itaf_front.sv =====
module itaf_front
  import itaf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] value,
  input  logic [3:0]  width,
  input  logic        zero_pad,
  output job_chan_t   chan,
  input  logic        pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          accept;
  job_t          cls;
  logic [3:0]    clip_w;

  // Clip the width to the radix and find the top digit position
  always_comb begin
    cls.hex       = (command == CMD_HEX);
    cls.value     = value;
    cls.zero_pad  = zero_pad;
    cls.has_width = (width != 4'd0);
    if (cls.hex) begin
      clip_w = (width > 4'(HEX_WIDTH_MAX)) ? 4'(HEX_WIDTH_MAX) : width;
    end else begin
      clip_w = (width > 4'(DEC_WIDTH_MAX)) ? 4'(DEC_WIDTH_MAX) : width;
    end
    if (cls.has_width) begin
      cls.top_pos = clip_w - 4'd1;
    end else if (cls.hex) begin
      cls.top_pos = 4'(HEX_DIGITS - 1);
    end else begin
      cls.top_pos = 4'(DEC_DIGITS - 1);
    end
  end

  assign in_stall   = (count == CW'(QUEUE_DEPTH));
  assign accept     = in_valid && !in_stall;
  assign chan.valid = (count != '0);
  assign chan.job   = q[rd_ptr];

  // Write classified words into the queue
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (accept && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !accept) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

// ===== hdl/itaf_back.sv =====
module itaf_back
  import itaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_chan_t  chan,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t      state;
  logic [39:0] digits;
  logic [31:0] bin;
  logic [3:0]  steps;
  logic [3:0]  pos;
  logic        lead;
  logic        has_width;
  logic        zero_pad_r;

  logic [71:0] dd_one;
  logic [71:0] dd_two;
  logic [3:0]  cur_digit;
  logic        lead_now;
  logic        skip;
  logic        slot_free;
  logic        emit;
  logic [7:0]  char_next;

  // One double-dabble step: adjust each BCD digit, then shift one bit in
  function automatic logic [71:0] dd_step(input logic [71:0] s);
    logic [71:0] a;
    a = s;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      if (a[32 + 4*k +: 4] >= 4'd5) begin
        a[32 + 4*k +: 4] = a[32 + 4*k +: 4] + 4'd3;
      end
    end
    return {a[70:0], 1'b0};
  endfunction

  assign dd_one = dd_step({digits, bin});
  assign dd_two = dd_step(dd_one);

  // Classify the current digit position
  assign cur_digit = digits[{pos, 2'b00} +: 4];
  assign lead_now  = lead && (cur_digit == 4'd0) && (pos != 4'd0);
  assign skip      = lead_now && !has_width;
  assign slot_free = !out_valid || !out_stall;
  assign emit      = (state == S_EMIT) && !skip && slot_free;
  assign pop       = (state == S_IDLE) && chan.valid;

  always_comb begin
    if (lead_now) begin
      char_next = zero_pad_r ? CHAR_ZERO : CHAR_SPACE;
    end else begin
      char_next = digit_char(cur_digit);
    end
  end

  // Sequence load, conversion and character emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            state <= chan.job.hex ? S_EMIT : S_CONV;
          end
        end
        S_CONV: begin
          if (steps == 4'd0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit && pos == 4'd0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold digits and position for the word in progress
  always_ff @(posedge clk) begin
    if (pop) begin
      bin        <= chan.job.value;
      digits     <= chan.job.hex ? {8'h00, chan.job.value} : 40'd0;
      steps      <= 4'd15;
      pos        <= chan.job.top_pos;
      lead       <= 1'b1;
      has_width  <= chan.job.has_width;
      zero_pad_r <= chan.job.zero_pad;
    end else if (state == S_CONV) begin
      {digits, bin} <= dd_two;
      steps         <= steps - 4'd1;
    end else if (state == S_EMIT && (skip || emit)) begin
      lead <= lead_now;
      if (pos != 4'd0) begin
        pos <= pos - 4'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      last     <= (pos == 4'd0);
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && pos == 4'd0) |=> state == S_IDLE)
    else $error("final character did not end the word");

  a_conv_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_CONV) |-> $past(state) == S_IDLE && steps == 4'd15)
    else $error("conversion started without a load");

  a_no_skip_width: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && has_width) |-> !skip)
    else $error("position dropped with a field width set");

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// Formats a 32-bit unsigned value as ASCII in decimal or upper-case hex, one
// character per output word, most significant first, with last set on the
// final one. A front stage clips the width and classifies each input word into
// a small queue (QUEUE_DEPTH entries), so new words are taken while the back
// end works. The back end loads a word; a decimal word then runs through a
// two-bit-per-cycle double-dabble converter. After that, the back end steps
// through every digit position from the top shown position down, whether the
// position emits a character or is a dropped leading zero: ten positions in
// decimal without width, w with width w (after clipping to 9), and eight or w
// in hex (w clipped to 8). A stalled output holds a position that emits a
// character until the output register is free.
module integer_to_ascii_formatter
  import itaf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] value,
  input  logic [3:0]  width,
  input  logic        zero_pad,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  job_chan_t chan;
  logic      pop;

  itaf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .value    (value),
    .width    (width),
    .zero_pad (zero_pad),
    .chan     (chan),
    .pop      (pop)
  );

  itaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .chan      (chan),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule
